### rtl/dsfd_pkg.sv
// Package for the digest string format detector.
// Holds request and result types, the scan state type, phase codes,
// character-class lookup and digest-size check. No dependencies.
package dsfd_pkg;

  localparam int MaxScanDefault = 129;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [3:0] FMT_HEX   = 4'b0001;
  localparam logic [3:0] FMT_B32L  = 4'b0010;
  localparam logic [3:0] FMT_B32U  = 4'b0100;
  localparam logic [3:0] FMT_B64   = 4'b1000;
  localparam logic [3:0] FMT_B32   = FMT_B32L | FMT_B32U;
  localparam logic [3:0] FMT_ALL   = 4'b1111;
  localparam logic [3:0] FMT_NONE  = 4'b0000;

  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [2:0] PAD_SAT   = 3'd4;
  localparam logic [2:0] PAD_MAX   = 3'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dsfd_in_t;

  typedef struct packed {
    logic [3:0] format_mask;
    logic [7:0] digit_length;
    logic [2:0] pad_count;
  } dsfd_out_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] allowed;
    logic [3:0] seen;
    logic [7:0] count;
    logic [2:0] equals;
  } dsfd_state_t;

  localparam dsfd_state_t STATE_RST = '{
    phase:   PH_SCAN,
    allowed: FMT_ALL,
    seen:    FMT_NONE,
    count:   8'd0,
    equals:  3'd0
  };

  // Class mask of one character: bit0 hex, bit1 base32 lower,
  // bit2 base32 upper, bit3 base64.
  function automatic logic [3:0] char_class(input logic [7:0] c);
    logic [3:0] cls;
    cls = FMT_NONE;
    if (c == 8'h2b || c == 8'h2f) begin
      cls = FMT_B64;
    end else if (c == 8'h30 || c == 8'h31 || c == 8'h38 || c == 8'h39) begin
      cls = FMT_HEX | FMT_B64;
    end else if (c >= 8'h32 && c <= 8'h37) begin
      cls = FMT_ALL;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      cls = FMT_HEX | FMT_B32U | FMT_B64;
    end else if (c >= 8'h47 && c <= 8'h5a) begin
      cls = FMT_B32U | FMT_B64;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      cls = FMT_HEX | FMT_B32L | FMT_B64;
    end else if (c >= 8'h67 && c <= 8'h7a) begin
      cls = FMT_B32L | FMT_B64;
    end
    return cls;
  endfunction

  // Supported digest sizes in bits.
  function automatic logic size_ok(input logic [11:0] bits);
    return bits == 12'd32  || bits == 12'd128 || bits == 12'd160 ||
           bits == 12'd192 || bits == 12'd224 || bits == 12'd256 ||
           bits == 12'd384 || bits == 12'd512;
  endfunction

endpackage

### rtl/dsfd_step.sv
// Per-character scan update and end-of-token verdict for the detector.
// Purely combinational; uses dsfd_pkg for types, codes and lookups.
module dsfd_step #(
  parameter int MAX_SCAN = dsfd_pkg::MaxScanDefault
) (
  input  dsfd_pkg::dsfd_state_t st,
  input  dsfd_pkg::dsfd_in_t    req,
  output dsfd_pkg::dsfd_state_t st_nxt,
  output dsfd_pkg::dsfd_out_t   res
);

  localparam logic [7:0] ScanLimit = 8'(MAX_SCAN);

  dsfd_pkg::dsfd_state_t upd;
  logic [3:0]  cand;
  logic        is_eq;
  logic [7:0]  n;
  logic [2:0]  pads;
  logic [11:0] n4;
  logic [11:0] n5;
  logic [11:0] n6;
  logic [11:0] b32_bits;
  logic [11:0] b64_bits;
  logic [7:0]  n_plus_pads;
  logic [3:0]  fmt;
  logic [3:0]  verdict;

  assign cand  = st.allowed & dsfd_pkg::char_class(req.ch);
  assign is_eq = (req.ch == dsfd_pkg::CH_EQUALS);

  always_comb begin
    upd = st;
    case (st.phase)
      dsfd_pkg::PH_SCAN: begin
        upd.allowed = cand;
        if (cand != dsfd_pkg::FMT_NONE && st.count < ScanLimit) begin
          upd.seen  = cand;
          upd.count = st.count + 8'd1;
        end else if (st.seen[3] && is_eq) begin
          upd.seen   = dsfd_pkg::FMT_B64;
          upd.equals = 3'd1;
          upd.phase  = dsfd_pkg::PH_PAD;
        end else begin
          upd.phase = dsfd_pkg::PH_DONE;
        end
      end
      dsfd_pkg::PH_PAD: begin
        if (is_eq) begin
          if (st.equals < dsfd_pkg::PAD_SAT) begin
            upd.equals = st.equals + 3'd1;
          end
        end else begin
          upd.phase = dsfd_pkg::PH_DONE;
        end
      end
      default: begin
        upd = st;
      end
    endcase
  end

  // Verdict on the updated state
  assign n           = upd.count;
  assign pads        = upd.equals;
  assign n4          = {2'b00, n, 2'b00};
  assign n5          = {2'b00, n, 2'b00} + {4'b0000, n};
  assign n6          = {2'b00, n, 2'b00} + {3'b000, n, 1'b0};
  assign b32_bits    = {n5[11:3], 3'b000};
  assign b64_bits    = {n6[11:3], 3'b000};
  assign n_plus_pads = n + {5'b00000, pads};

  always_comb begin
    fmt = upd.seen;
    // Base64 needs at most three pads, a length that is a multiple of four
    // and the shortest digit count for its bit length.
    if (fmt[3]) begin
      if (pads > dsfd_pkg::PAD_MAX || n_plus_pads[1:0] != 2'b00 ||
          n6[2:0] >= 3'd6) begin
        fmt[3] = 1'b0;
      end
    end
    verdict = dsfd_pkg::FMT_NONE;
    if (fmt[0] && dsfd_pkg::size_ok(n4)) begin
      verdict = verdict | dsfd_pkg::FMT_HEX;
    end
    if ((fmt[1] || fmt[2]) && dsfd_pkg::size_ok(b32_bits)) begin
      verdict = verdict | dsfd_pkg::FMT_B32;
    end
    if (fmt[3] && dsfd_pkg::size_ok(b64_bits)) begin
      verdict = verdict | dsfd_pkg::FMT_B64;
    end
  end

  assign res.format_mask  = verdict;
  assign res.digit_length = (verdict != dsfd_pkg::FMT_NONE) ? n : 8'd0;
  assign res.pad_count    = pads;

  assign st_nxt = req.last ? dsfd_pkg::STATE_RST : upd;

endmodule

### rtl/digest_string_format_detector.sv
// Digest string format detector: one character per cycle; the result of a token goes
// valid once the request carrying last passes from the input register to the result register.
// Throughput is one request per cycle while no final character is stalled; the scan update is combinational.
// A full result register with out_ready low stalls only requests that carry last.
// rst_n (synchronous) empties both registers and returns the scan to its start.
module digest_string_format_detector #(
  parameter int MAX_SCAN = dsfd_pkg::MaxScanDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsfd_pkg::dsfd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsfd_pkg::dsfd_out_t out_data
);

  logic                  in_v_r;
  dsfd_pkg::dsfd_in_t    in_d_r;
  dsfd_pkg::dsfd_state_t st_r;
  dsfd_pkg::dsfd_state_t st_nxt;
  dsfd_pkg::dsfd_out_t   res;
  logic                  out_v_r;
  dsfd_pkg::dsfd_out_t   out_d_r;
  logic                  adv;

  dsfd_step #(
    .MAX_SCAN(MAX_SCAN)
  ) u_step (
    .st     (st_r),
    .req    (in_d_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Non-final characters never wait on the result side
  assign adv      = in_v_r && (!in_d_r.last || !out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dsfd_pkg::STATE_RST;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && in_d_r.last) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_d_r.last) begin
      out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_b32_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_d_r.format_mask[1] == out_d_r.format_mask[2])
    else $error("base32 format bits differ");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_d_r.format_mask == dsfd_pkg::FMT_NONE) ==
                 (out_d_r.digit_length == 8'd0)))
    else $error("digit length disagrees with format mask");

  a_b64_pads: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_d_r.format_mask[3] |-> out_d_r.pad_count <= dsfd_pkg::PAD_MAX)
    else $error("base64 accepted with too many pads");

  a_token_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_d_r.last |=> st_r == dsfd_pkg::STATE_RST && out_v_r)
    else $error("scan state not restarted after final character");

  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && in_d_r.last && out_v_r && !out_ready |=> $stable(st_r) && in_v_r)
    else $error("final character advanced into an occupied result register");

endmodule
